FILE: src/sbm_pkg.sv
// Shared constants, types and control bundles for the sort-based median core.
package sbm_pkg;

  localparam int MAX_COUNT = 64;
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int SMP_W     = 32;
  localparam int MED_W     = 33;
  localparam int SIZE_W    = 7;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SHIFT,
    ST_FINISH
  } st_t;

  typedef struct packed {
    logic ins_en;    // insert accepted word into the sorted row
    logic close;     // set closes: arm the shift counter
    logic shift_en;  // move the row one cell toward cell 0
    logic capture;   // load result register, clear set state
  } cmd_t;

  typedef struct packed {
    logic shift_zero;
  } sts_t;

endpackage

FILE: src/sort_based_median_core.sv
// Top level of the sort-based median core: stream ports, controller and datapath.
//
// Collects a set of signed 32-bit words, keeping them in descending order in a
// row of MAX_COUNT (64) compare-and-shift cells as they arrive, one word per
// cycle while loading. The word with in_tlast closes the set. The row is then
// shifted toward cell 0 by floor((n-1)/2) places (n = kept count). Once the
// controller sees the shift count at zero, a finish state captures twice the
// median: 2*middle for odd n, sum of the two middle words for even n, exact in
// 33 bits. in_tready stays low from the close until that capture. Words past
// 64 are dropped and flag overflowed; the set still closes on its last word.
// The result sits in an output register, so a new set loads while the previous
// result waits; the finish of a second set stalls only if the first result is
// still untaken. Cell contents need no reset.
module sort_based_median_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic        in_tlast,   // last word of the set
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [32:0] median_twice, [39:33] set_size
  output logic        out_tuser   // overflowed
);
  import sbm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic signed [MED_W-1:0] median_twice;
  logic [SIZE_W-1:0]       set_size;
  logic                    overflowed;

  sbm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sbm_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample       (in_tdata),
    .cmd          (cmd),
    .sts          (sts),
    .median_twice (median_twice),
    .set_size     (set_size),
    .overflowed   (overflowed)
  );

  // Result word packing: median in the low bits, set size above it.
  assign out_tdata = {set_size, median_twice};
  assign out_tuser = overflowed;

endmodule

FILE: src/sbm_ctrl.sv
// Controller: load / shift / finish sequencing and output valid tracking.
module sbm_ctrl (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tlast,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  sbm_pkg::sts_t sts,
  output sbm_pkg::cmd_t cmd
);
  import sbm_pkg::*;

  st_t  state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept && in_tlast) state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (sts.shift_zero) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_tready    = (state_r == ST_LOAD);
    cmd.ins_en   = 1'b0;
    cmd.close    = 1'b0;
    cmd.shift_en = 1'b0;
    cmd.capture  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        cmd.ins_en = accept;
        cmd.close  = accept && in_tlast;
      end
      ST_SHIFT: begin
        cmd.shift_en = !sts.shift_zero;
      end
      ST_FINISH: begin
        cmd.capture = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.capture) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: src/sbm_dpath.sv
// Datapath: sorted insertion row, fill count, drop flag, shift counter, result register.
module sbm_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [sbm_pkg::SMP_W-1:0]  sample,
  input  sbm_pkg::cmd_t                     cmd,
  output sbm_pkg::sts_t                     sts,
  output logic signed [sbm_pkg::MED_W-1:0]  median_twice,
  output logic [sbm_pkg::SIZE_W-1:0]        set_size,
  output logic                              overflowed
);
  import sbm_pkg::*;

  logic signed [SMP_W-1:0] cell_r   [MAX_COUNT];
  logic signed [SMP_W-1:0] cell_nxt [MAX_COUNT];
  logic [MAX_COUNT-1:0]    ins;
  logic [CNT_W-1:0]        cnt_r, cnt_ins;
  logic [CNT_W-1:0]        sh_r;
  logic                    drop_r;
  logic                    full;
  logic signed [MED_W-1:0] med;
  logic signed [MED_W-1:0] med_r;
  logic [SIZE_W-1:0]       size_r;
  logic                    ovf_r;

  assign full    = (cnt_r == CNT_W'(MAX_COUNT));
  assign cnt_ins = full ? cnt_r : cnt_r + CNT_W'(1);

  // Row is kept in descending order; ins marks cells at or past the insertion point.
  always_comb begin
    for (int i = 0; i < MAX_COUNT; i++) begin
      ins[i] = (CNT_W'(i) >= cnt_r) || (cell_r[i] < sample);
    end
  end

  always_comb begin
    cell_nxt = cell_r;
    if (cmd.ins_en && !full) begin
      if (ins[0]) cell_nxt[0] = sample;
      for (int i = 1; i < MAX_COUNT; i++) begin
        if (ins[i]) cell_nxt[i] = ins[i-1] ? cell_r[i-1] : sample;
      end
    end else if (cmd.shift_en) begin
      for (int i = 0; i < MAX_COUNT - 1; i++) begin
        cell_nxt[i] = cell_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
      sh_r   <= '0;
    end else begin
      if (cmd.ins_en) begin
        if (full) drop_r <= 1'b1;
        else cnt_r <= cnt_ins;
      end
      if (cmd.close) sh_r <= (cnt_ins - CNT_W'(1)) >> 1;
      else if (cmd.shift_en) sh_r <= sh_r - CNT_W'(1);
      if (cmd.capture) begin
        cnt_r  <= '0;
        drop_r <= 1'b0;
      end
    end
  end

  assign sts.shift_zero = (sh_r == '0);

  // After the shift, cell 0 holds the lower middle index of the descending order.
  always_comb begin
    if (cnt_r[0]) med = {cell_r[0], 1'b0};
    else med = {cell_r[0][SMP_W-1], cell_r[0]} + {cell_r[1][SMP_W-1], cell_r[1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      med_r  <= med;
      size_r <= SIZE_W'(cnt_r);
      ovf_r  <= drop_r;
    end
  end

  assign median_twice = med_r;
  assign set_size     = size_r;
  assign overflowed   = ovf_r;

endmodule

FILE: src/sbm_checker.sv
// Port-level checker for the sort-based median core, bound to the top level.
module sbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // A result waiting for the sink holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // Closing a set stops input while the row drains.
  a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after set close");

  // Every result reports a non-empty set of at most 64 words.
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] != 7'd0 && out_tdata[39:33] <= 7'd64)
    else $error("set size out of range");

  // Words are dropped only once the buffer is full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[39:33] == 7'd64)
    else $error("overflow flagged below full set");

endmodule

bind sort_based_median_core sbm_checker u_sbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
